// ----- design/ccc_pkg.sv -----
`default_nettype none

package ccc_pkg;

    localparam int COORD_W    = 12;
    localparam int COLOR_W    = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_TEXT_MODE     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_FG_COLOR      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_BG_COLOR      = 3'd4;

    // register reset values
    localparam logic [COORD_W-1:0] SCREEN_WIDTH_RST  = 12'd640;
    localparam logic [COORD_W-1:0] SCREEN_HEIGHT_RST = 12'd480;
    localparam logic [COLOR_W-1:0] FG_COLOR_RST      = 32'h0000_0000;
    localparam logic [COLOR_W-1:0] BG_COLOR_RST      = 32'hFFFF_FFFF;

    // request codes
    localparam logic OP_PUT   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // character codes
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_TAB       = 8'd9;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_RETURN    = 8'd13;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    typedef enum logic [1:0] {
        CMD_DRAW   = 2'd0,
        CMD_SCROLL = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        K_CLEAR     = 3'd0,
        K_NEWLINE   = 3'd1,
        K_RETURN    = 3'd2,
        K_BACKSPACE = 3'd3,
        K_PRINT     = 3'd4
    } kind_t;

    typedef struct packed {
        logic [COORD_W-1:0] screen_width;
        logic [COORD_W-1:0] screen_height;
        logic               text_mode;
        logic [COLOR_W-1:0] fg_color;
        logic [COLOR_W-1:0] bg_color;
        logic [COORD_W-1:0] width_cells;   // screen_width / font width
    } cfg_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [7:0]         glyph;
        logic               last;
    } res_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] glyph;
        logic       scroll;       // scroll result pending after a draw
        logic       final_draw;   // the draw at hand is the last one
        logic       no_draws;     // no draws left
    } work_t;

    typedef struct packed {
        logic  res_valid;
        res_t  res;
        logic  done;
        logic  scroll_next;
        logic  draw;
    } step_t;

endpackage

`default_nettype wire

// ----- design/ccc_cfg_regs.sv -----
`default_nettype none

module ccc_cfg_regs #(
    parameter int FONT_WIDTH = 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [ccc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [ccc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output ccc_pkg::cfg_t                       cfg
);
    import ccc_pkg::*;

    // width / font width by reciprocal multiply, exact for 12-bit widths
    localparam int            QSHIFT    = 24;
    localparam int            RECIP_W   = QSHIFT + 1;
    localparam int            PROD_W    = COORD_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((2 ** QSHIFT) + FONT_WIDTH - 1) / FONT_WIDTH);
    localparam logic [COORD_W-1:0] CELLS_RST =
        COORD_W'(int'(SCREEN_WIDTH_RST) / FONT_WIDTH);

    cfg_t              cfg_reg;
    logic [PROD_W-1:0] width_prod;
    logic [COORD_W-1:0] width_cells;

    always_comb
    begin
        width_prod  = PROD_W'(cfg_wdata[COORD_W-1:0]) * PROD_W'(RECIP);
        width_cells = width_prod[QSHIFT +: COORD_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_width  <= SCREEN_WIDTH_RST;
            cfg_reg.screen_height <= SCREEN_HEIGHT_RST;
            cfg_reg.text_mode     <= 1'b0;
            cfg_reg.fg_color      <= FG_COLOR_RST;
            cfg_reg.bg_color      <= BG_COLOR_RST;
            cfg_reg.width_cells   <= CELLS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_SCREEN_WIDTH:
                begin
                    cfg_reg.screen_width <= cfg_wdata[COORD_W-1:0];
                    cfg_reg.width_cells  <= width_cells;
                end
                REG_SCREEN_HEIGHT: cfg_reg.screen_height <= cfg_wdata[COORD_W-1:0];
                REG_TEXT_MODE:     cfg_reg.text_mode     <= cfg_wdata[0];
                REG_FG_COLOR:      cfg_reg.fg_color      <= cfg_wdata[COLOR_W-1:0];
                REG_BG_COLOR:      cfg_reg.bg_color      <= cfg_wdata[COLOR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- design/ccc_step.sv -----
`default_nettype none

module ccc_step #(
    parameter int FONT_WIDTH  = 8,
    parameter int FONT_HEIGHT = 16
) (
    input  wire ccc_pkg::work_t              work,
    input  wire logic [ccc_pkg::COORD_W-1:0] col,
    input  wire logic [ccc_pkg::COORD_W-1:0] row,
    input  wire ccc_pkg::cfg_t               cfg,
    output ccc_pkg::step_t                   step,
    output logic [ccc_pkg::COORD_W-1:0]      step_col,
    output logic [ccc_pkg::COORD_W-1:0]      step_row
);
    import ccc_pkg::*;

    localparam int                  PROD_W = COORD_W + 5;
    localparam logic [COORD_W+1:0]  FW14   = (COORD_W + 2)'(FONT_WIDTH);
    localparam logic [COORD_W-1:0]  FW12   = COORD_W'(FONT_WIDTH);
    localparam logic [COORD_W:0]    FH13   = (COORD_W + 1)'(FONT_HEIGHT);
    localparam logic [COORD_W-1:0]  FH12   = COORD_W'(FONT_HEIGHT);

    function automatic logic [COORD_W-1:0] row_up(input logic [COORD_W-1:0] r);
        logic [COORD_W-1:0] v;
        v = (r >= FH12) ? (r - FH12) : '0;
        return v;
    endfunction

    logic [COORD_W+1:0]  col_adv;
    logic                wrap;
    logic [COORD_W-1:0]  pcol, prow;
    logic                psc;
    logic [COORD_W-1:0]  nrow;
    logic                nsc;
    logic [COORD_W-1:0]  bs_step, bs_wrap_col, bcol, brow;
    logic [PROD_W-1:0]   bs_prod;

    // printable advance and scroll test
    always_comb
    begin
        col_adv = {2'b00, col} + FW14;
        wrap    = !cfg.text_mode && ((col_adv + FW14) >= {2'b00, cfg.screen_width});
        if (cfg.text_mode)
        begin
            pcol = col + COORD_W'(1);
            prow = row;
        end
        else if (wrap)
        begin
            pcol = '0;
            prow = row + FH12;
        end
        else
        begin
            pcol = col_adv[COORD_W-1:0];
            prow = row;
        end
        psc  = ({1'b0, prow} + FH13) >= {1'b0, cfg.screen_height};
        nrow = row + FH12;
        nsc  = ({1'b0, nrow} + FH13) >= {1'b0, cfg.screen_height};
    end

    // backspace target, wrapping to the last whole cell of the line above
    always_comb
    begin
        bs_step = cfg.text_mode ? COORD_W'(1) : FW12;
        bs_prod = PROD_W'(cfg.width_cells - COORD_W'(1)) * PROD_W'(FONT_WIDTH);
        if (cfg.text_mode)
            bs_wrap_col = (cfg.screen_width == '0) ? '0
                                                    : cfg.screen_width - COORD_W'(1);
        else
            bs_wrap_col = (cfg.width_cells == '0) ? '0 : bs_prod[COORD_W-1:0];
        if (col >= bs_step)
        begin
            bcol = col - bs_step;
            brow = row;
        end
        else if (row >= FH12)
        begin
            bcol = bs_wrap_col;
            brow = row - FH12;
        end
        else
        begin
            bcol = col;
            brow = row;
        end
    end

    always_comb
    begin
        step.res_valid   = 1'b0;
        step.res.cmd     = CMD_DRAW;
        step.res.pos_x   = '0;
        step.res.pos_y   = '0;
        step.res.glyph   = '0;
        step.res.last    = 1'b0;
        step.done        = 1'b1;
        step.scroll_next = 1'b0;
        step.draw        = 1'b0;
        step_col         = col;
        step_row         = row;

        if (work.scroll)
        begin
            step.res_valid = 1'b1;
            step.res.cmd   = CMD_SCROLL;
            step.res.last  = work.no_draws;
            step.done      = work.no_draws;
            step_row       = row_up(row);
        end
        else
        begin
            unique case (work.kind)
                K_CLEAR:
                begin
                    step.res_valid = 1'b1;
                    step.res.cmd   = CMD_CLEAR;
                    step.res.last  = 1'b1;
                    step_col       = '0;
                    step_row       = '0;
                end
                K_NEWLINE:
                begin
                    step_col = '0;
                    if (nsc)
                    begin
                        step.res_valid = 1'b1;
                        step.res.cmd   = CMD_SCROLL;
                        step.res.last  = 1'b1;
                        step_row       = row_up(nrow);
                    end
                    else
                        step_row = nrow;
                end
                K_RETURN:
                    step_col = '0;
                K_BACKSPACE:
                begin
                    step.res_valid = 1'b1;
                    step.res.pos_x = bcol;
                    step.res.pos_y = brow;
                    step.res.glyph = CH_SPACE;
                    step.res.last  = 1'b1;
                    step_col       = bcol;
                    step_row       = brow;
                end
                K_PRINT:
                begin
                    step.res_valid   = 1'b1;
                    step.res.pos_x   = col;
                    step.res.pos_y   = row;
                    step.res.glyph   = work.glyph;
                    step.res.last    = !psc && work.final_draw;
                    step.done        = !psc && work.final_draw;
                    step.scroll_next = psc;
                    step.draw        = 1'b1;
                    step_col         = pcol;
                    step_row         = prow;
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- design/ccc_out_stage.sv -----
`default_nettype none

module ccc_out_stage (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        load,
    input  wire ccc_pkg::res_t               res,
    input  wire logic [ccc_pkg::COLOR_W-1:0] fg_color,
    input  wire logic [ccc_pkg::COLOR_W-1:0] bg_color,
    input  wire logic                        out_ready,
    output logic                             out_free,
    output logic                             out_valid,
    output ccc_pkg::res_t                    out_res,
    output logic [ccc_pkg::COLOR_W-1:0]      out_ink,
    output logic [ccc_pkg::COLOR_W-1:0]      out_paper
);
    import ccc_pkg::*;

    logic               valid_reg, valid_next;
    res_t               res_reg;
    logic [COLOR_W-1:0] ink_reg, paper_reg;

    // room for a new result when empty or when the held one leaves now
    assign out_free   = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg   <= res;
            ink_reg   <= fg_color;
            paper_reg <= bg_color;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;
    assign out_ink   = ink_reg;
    assign out_paper = paper_reg;

endmodule

`default_nettype wire

// ----- design/console_cursor_controller_top.sv -----
`default_nettype none

// Console cursor controller: takes one put-character or clear request per
// transfer on the input channel and keeps the cursor column and row. For each
// request it sends zero or more draw, scroll or clear commands to a glyph
// renderer on the output channel, the final one flagged with last. Carriage
// return sends nothing; a newline sends a scroll only when the cursor hits the
// bottom. One request sits in a work register and a single step unit handles
// one sub-step per cycle while the output stage has room for its command: a
// printable character is a draw, followed by a scroll when one is due; a tab
// is TAB_SPACES draws, each possibly followed by a scroll; backspace, clear,
// carriage return and newline are a single sub-step. The next request is taken
// in the cycle the current one finishes, and the output register lets a
// command wait for the renderer while the next one is being worked out. The
// first command of a request passes through the work register and then the
// output register. Configuration writes are registered and must happen while
// no request is in flight; a screen_width write also latches width /
// FONT_WIDTH for backspace wrapping.
module console_cursor_controller_top #(
    parameter int FONT_WIDTH  = 8,
    parameter int FONT_HEIGHT = 16,
    parameter int TAB_SPACES  = 4
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // request channel
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           op,
    input  wire logic [7:0]                     ch,
    // command channel
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [1:0]                          cmd,
    output logic [ccc_pkg::COORD_W-1:0]         pos_x,
    output logic [ccc_pkg::COORD_W-1:0]         pos_y,
    output logic [7:0]                          glyph,
    output logic [ccc_pkg::COLOR_W-1:0]         ink_color,
    output logic [ccc_pkg::COLOR_W-1:0]         paper_color,
    output logic                                last,
    // configuration write port
    input  wire logic                           cfg_we,
    input  wire logic [ccc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [ccc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import ccc_pkg::*;

    localparam int                CNT_W   = $clog2(TAB_SPACES + 1);
    localparam logic [CNT_W-1:0]  TAB_CNT = CNT_W'(TAB_SPACES);
    localparam logic [CNT_W-1:0]  ONE_CNT = CNT_W'(1);

    cfg_t                cfg;
    work_t               work;
    step_t               step;
    res_t                out_res;
    logic [COORD_W-1:0]  step_col, step_row;

    // work register: the request being handled
    logic                busy_reg, busy_next;
    kind_t               kind_reg, kind_next;
    logic [7:0]          glyph_reg, glyph_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;      // draws still to do
    logic                scroll_reg, scroll_next;

    // cursor state
    logic [COORD_W-1:0]  col_reg, col_next;
    logic [COORD_W-1:0]  row_reg, row_next;

    logic                out_free;
    logic                advance;   // step unit result taken this cycle
    logic                finish;    // request completes this cycle
    logic                accept;    // input transfer

    ccc_cfg_regs #(
        .FONT_WIDTH (FONT_WIDTH)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    assign work.kind       = kind_reg;
    assign work.glyph      = glyph_reg;
    assign work.scroll     = scroll_reg;
    assign work.final_draw = (cnt_reg == ONE_CNT);
    assign work.no_draws   = (cnt_reg == '0);

    ccc_step #(
        .FONT_WIDTH  (FONT_WIDTH),
        .FONT_HEIGHT (FONT_HEIGHT)
    ) u_step (
        .work     (work),
        .col      (col_reg),
        .row      (row_reg),
        .cfg      (cfg),
        .step     (step),
        .step_col (step_col),
        .step_row (step_row)
    );

    // a sub-step with no command never waits on the output side
    assign advance  = busy_reg && (!step.res_valid || out_free);
    assign finish   = advance && step.done;
    assign in_ready = !busy_reg || finish;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        busy_next   = busy_reg;
        kind_next   = kind_reg;
        glyph_next  = glyph_reg;
        cnt_next    = cnt_reg;
        scroll_next = scroll_reg;
        col_next    = col_reg;
        row_next    = row_reg;

        if (advance)
        begin
            col_next    = step_col;
            row_next    = step_row;
            scroll_next = step.scroll_next;
            if (step.draw)
                cnt_next = cnt_reg - ONE_CNT;
        end

        if (finish)
            busy_next = 1'b0;

        // decode a new request
        if (accept)
        begin
            busy_next   = 1'b1;
            scroll_next = 1'b0;
            cnt_next    = ONE_CNT;
            glyph_next  = ch;
            if (op == OP_CLEAR)
                kind_next = K_CLEAR;
            else
            begin
                unique case (ch)
                    CH_NEWLINE:   kind_next = K_NEWLINE;
                    CH_RETURN:    kind_next = K_RETURN;
                    CH_BACKSPACE: kind_next = K_BACKSPACE;
                    CH_TAB:
                    begin
                        kind_next  = K_PRINT;
                        glyph_next = CH_SPACE;
                        cnt_next   = TAB_CNT;
                    end
                    default:      kind_next = K_PRINT;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            cnt_reg    <= '0;
            scroll_reg <= 1'b0;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            busy_reg   <= busy_next;
            cnt_reg    <= cnt_next;
            scroll_reg <= scroll_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        glyph_reg <= glyph_next;
    end

    ccc_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && step.res_valid),
        .res       (step.res),
        .fg_color  (cfg.fg_color),
        .bg_color  (cfg.bg_color),
        .out_ready (out_ready),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_res   (out_res),
        .out_ink   (ink_color),
        .out_paper (paper_color)
    );

    assign cmd   = out_res.cmd;
    assign pos_x = out_res.pos_x;
    assign pos_y = out_res.pos_y;
    assign glyph = out_res.glyph;
    assign last  = out_res.last;

    // a pending scroll only follows a character draw
    a_scroll_after_draw: assert property (@(posedge clk) disable iff (!rst_n)
        scroll_reg |-> (busy_reg && kind_reg == K_PRINT))
        else $error("scroll pending outside a character request");

    // clear homes the cursor
    a_clear_homes: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !scroll_reg && kind_reg == K_CLEAR) |=>
            (col_reg == '0 && row_reg == '0))
        else $error("cursor not homed after clear");

    // the command that ends a request carries last
    a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && step.res_valid && step.done) |-> step.res.last)
        else $error("final command of a request without last");

    // a command that cannot leave holds off the next request
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && step.res_valid && !out_free) |-> !in_ready)
        else $error("request taken while a command is stalled");

    // a finished request with nothing new leaves the block idle
    a_idle_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && !accept) |=> !busy_reg)
        else $error("work register still busy after completion");

endmodule

`default_nettype wire

// ----- tb/sv/console_cursor_controller_top_test.sv -----
`timescale 1ns / 100ps

module console_cursor_controller_top_test;

    import ccc_pkg::*;

    // geometry the block is built with
    localparam int FONT_W = 8;
    localparam int FONT_H = 16;
    localparam int TAB_N  = 4;

    // cycles allowed for a request with no command (carriage return) to retire
    localparam int SETTLE_CYCLES = 10;
    localparam int REQ_PER_PHASE = 31;
    localparam int RAND_PHASES   = 6;
    // the slowest correct run stays far inside this limit
    localparam int TIMEOUT_NS    = 400_000;

    // one command as the renderer sees it
    typedef struct packed {
        cmd_t               kind;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [7:0]         g;
        logic [COLOR_W-1:0] ink;
        logic [COLOR_W-1:0] paper;
        logic               fin;
    } render_cmd_t;

    // tracks the cursor and the register file, and holds the commands still owed
    class render_cmd_tracker;
        render_cmd_t pending_cmds[$];
        int          cur_x;
        int          cur_y;
        int          scr_w;
        int          scr_h;
        bit          txt;
        logic [COLOR_W-1:0] ink;
        logic [COLOR_W-1:0] paper;
        int          errors;
        int          n_req;
        int          n_draw;
        int          n_scroll;
        int          n_clear;
        int          n_seen;

        function new();
            scr_w    = SCREEN_WIDTH_RST;
            scr_h    = SCREEN_HEIGHT_RST;
            txt      = 1'b0;
            ink      = FG_COLOR_RST;
            paper    = BG_COLOR_RST;
            cur_x    = 0;
            cur_y    = 0;
            errors   = 0;
            n_req    = 0;
            n_draw   = 0;
            n_scroll = 0;
            n_clear  = 0;
            n_seen   = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_SCREEN_WIDTH:  scr_w = data[COORD_W-1:0];
                REG_SCREEN_HEIGHT: scr_h = data[COORD_W-1:0];
                REG_TEXT_MODE:     txt   = data[0];
                REG_FG_COLOR:      ink   = data[COLOR_W-1:0];
                REG_BG_COLOR:      paper = data[COLOR_W-1:0];
                default:           ;
            endcase
        endfunction

        function void push_cmd(cmd_t k, int x, int y, logic [7:0] g);
            render_cmd_t c;
            c.kind  = k;
            c.x     = x[COORD_W-1:0];
            c.y     = y[COORD_W-1:0];
            c.g     = g;
            c.ink   = ink;
            c.paper = paper;
            c.fin   = 1'b0;
            pending_cmds.push_back(c);
            case (k)
                CMD_DRAW:   n_draw++;
                CMD_SCROLL: n_scroll++;
                default:    n_clear++;
            endcase
        endfunction

        function void scroll_if_bottom();
            if (cur_y + FONT_H >= scr_h) begin
                push_cmd(CMD_SCROLL, 0, 0, 8'h00);
                cur_y = (cur_y >= FONT_H) ? cur_y - FONT_H : 0;
            end
        endfunction

        function void draw_and_advance(logic [7:0] g);
            int nx;
            push_cmd(CMD_DRAW, cur_x, cur_y, g);
            if (txt) begin
                cur_x = (cur_x + 1) % 4096;
            end
            else begin
                nx = cur_x + FONT_W;
                if (nx + FONT_W >= scr_w) begin
                    nx    = 0;
                    cur_y = (cur_y + FONT_H) % 4096;
                end
                cur_x = nx % 4096;
            end
            scroll_if_bottom();
        endfunction

        function void step_back();
            int stride;
            int wrap_x;
            stride = txt ? 1 : FONT_W;
            if (cur_x >= stride) begin
                cur_x = cur_x - stride;
            end
            else if (cur_y >= FONT_H) begin
                wrap_x = scr_w - (scr_w % stride) - stride;
                cur_y  = cur_y - FONT_H;
                cur_x  = (wrap_x < 0) ? 0 : wrap_x % 4096;
            end
            push_cmd(CMD_DRAW, cur_x, cur_y, CH_SPACE);
        endfunction

        function void note_request(logic req_op, logic [7:0] req_ch);
            int          start;
            render_cmd_t tail;
            start = pending_cmds.size();
            n_req++;
            if (req_op == OP_CLEAR) begin
                push_cmd(CMD_CLEAR, 0, 0, 8'h00);
                cur_x = 0;
                cur_y = 0;
            end
            else begin
                case (req_ch)
                    CH_NEWLINE: begin
                        cur_x = 0;
                        cur_y = (cur_y + FONT_H) % 4096;
                        scroll_if_bottom();
                    end
                    CH_BACKSPACE: step_back();
                    CH_TAB: begin
                        for (int i = 0; i < TAB_N; i++)
                            draw_and_advance(CH_SPACE);
                    end
                    CH_RETURN: cur_x = 0;
                    default:   draw_and_advance(req_ch);
                endcase
            end
            if (pending_cmds.size() > start) begin
                tail     = pending_cmds.pop_back();
                tail.fin = 1'b1;
                pending_cmds.push_back(tail);
            end
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("mismatch %0d: %s", errors, what);
        endtask

        task check_cmd(render_cmd_t got);
            render_cmd_t want;
            n_seen++;
            if (pending_cmds.size() == 0) begin
                report_mismatch($sformatf("command %0d at (%0d,%0d) with none expected",
                                          got.kind, got.x, got.y));
                return;
            end
            want = pending_cmds.pop_front();
            if (got.kind !== want.kind)
                report_mismatch($sformatf("cmd %0d, want %0d", got.kind, want.kind));
            if (got.x !== want.x)
                report_mismatch($sformatf("pos_x %0d, want %0d", got.x, want.x));
            if (got.y !== want.y)
                report_mismatch($sformatf("pos_y %0d, want %0d", got.y, want.y));
            if (got.g !== want.g)
                report_mismatch($sformatf("glyph %h, want %h", got.g, want.g));
            if (got.ink !== want.ink)
                report_mismatch($sformatf("ink_color %h, want %h", got.ink, want.ink));
            if (got.paper !== want.paper)
                report_mismatch($sformatf("paper_color %h, want %h", got.paper, want.paper));
            if (got.fin !== want.fin)
                report_mismatch($sformatf("last %b, want %b", got.fin, want.fin));
        endtask

        function int pending();
            return pending_cmds.size();
        endfunction
    endclass

    // every block input starts at a known value
    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  in_ready;
    logic                  op          = OP_PUT;
    logic [7:0]            ch          = 8'h00;
    logic                  out_valid;
    logic                  out_ready   = 1'b0;
    logic [1:0]            cmd;
    logic [COORD_W-1:0]    pos_x;
    logic [COORD_W-1:0]    pos_y;
    logic [7:0]            glyph;
    logic [COLOR_W-1:0]    ink_color;
    logic [COLOR_W-1:0]    paper_color;
    logic                  last;
    logic                  cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr    = REG_SCREEN_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_wdata   = '0;

    render_cmd_tracker tracker = new();
    // when set, neither side idles
    bit                calm = 1'b0;
    int                settings_used = 0;

    console_cursor_controller_top #(
        .FONT_WIDTH  (FONT_W),
        .FONT_HEIGHT (FONT_H),
        .TAB_SPACES  (TAB_N)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .ch          (ch),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cmd         (cmd),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .glyph       (glyph),
        .ink_color   (ink_color),
        .paper_color (paper_color),
        .last        (last),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata)
    );

    // 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // idle with a chance of about 21 in a hundred unless a calm stretch is on
    function automatic bit take_break();
        return !calm && ($urandom_range(99) < 21);
    endfunction

    // screen extent: mostly small so wraps and scrolls come often, sometimes
    // the maximum or any 12-bit value, zero included
    function automatic int pick_extent();
        case ($urandom_range(3))
            0:       return $urandom_range(64, 1);
            1:       return $urandom_range(700, 65);
            2:       return 4095;
            default: return $urandom_range(4095);
        endcase
    endfunction

    // one request transfer; valid stays up with the payload until in_ready
    task automatic send_request(logic req_op, logic [7:0] req_ch);
        while (take_break())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= req_op;
        ch       <= req_ch;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        tracker.note_request(req_op, req_ch);
    endtask

    // hold off the sender until every owed command is back, then give a
    // silent request (carriage return, quiet newline) time to retire
    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // writes all five registers back to back; only called with the block idle;
    // junk in the unused upper bits checks that the block masks them
    task automatic configure(int w, int h, bit txt_on, logic [31:0] fg, logic [31:0] bg);
        logic [CFG_ADDR_W-1:0] addrs [5];
        logic [CFG_DATA_W-1:0] vals  [5];
        addrs = '{REG_SCREEN_WIDTH, REG_SCREEN_HEIGHT, REG_TEXT_MODE, REG_FG_COLOR,
                  REG_BG_COLOR};
        vals[0]        = $urandom();
        vals[0][11:0]  = w[11:0];
        vals[1]        = $urandom();
        vals[1][11:0]  = h[11:0];
        vals[2]        = $urandom();
        vals[2][0]     = txt_on;
        vals[3]        = fg;
        vals[4]        = bg;
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_addr  <= addrs[i];
            cfg_wdata <= vals[i];
            @(posedge clk);
            tracker.write_reg(addrs[i], vals[i]);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    // command side: outputs are sampled at the edge, ready is changed after it
    initial
    begin : command_side
        render_cmd_t got;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_ready) begin
                got.kind  = cmd_t'(cmd);
                got.x     = pos_x;
                got.y     = pos_y;
                got.g     = glyph;
                got.ink   = ink_color;
                got.paper = paper_color;
                got.fin   = last;
                tracker.check_cmd(got);
            end
            out_ready <= !take_break();
        end
    end

    // request side: reset, directed requests, then random phases
    initial
    begin : request_side
        int         r;
        logic       rop;
        logic [7:0] rch;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: code extremes, tab, backspace in place, at the origin
        // and wrapping onto the line above, clear
        send_request(OP_PUT, 8'h41);
        send_request(OP_PUT, 8'hFF);
        send_request(OP_PUT, 8'h00);
        send_request(OP_PUT, CH_TAB);
        send_request(OP_PUT, CH_BACKSPACE);
        send_request(OP_PUT, CH_RETURN);
        send_request(OP_PUT, CH_BACKSPACE);
        send_request(OP_PUT, CH_NEWLINE);
        send_request(OP_PUT, CH_BACKSPACE);
        send_request(OP_PUT, 8'h42);
        send_request(OP_CLEAR, 8'hFF);
        settle();

        // tiny screen with swapped color extremes: tab and newline scroll
        configure(24, 40, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(OP_PUT, 8'h78);
        send_request(OP_PUT, 8'h79);
        send_request(OP_PUT, CH_TAB);
        send_request(OP_PUT, CH_NEWLINE);
        settle();

        // zero width and height 1: every draw wraps and every line move scrolls
        configure(0, 1, 1'b0, $urandom(), $urandom());
        send_request(OP_PUT, 8'h7A);
        send_request(OP_PUT, CH_NEWLINE);
        settle();

        // zero width, full height: backspace wrap target below zero clamps
        configure(0, 4095, 1'b0, $urandom(), $urandom());
        send_request(OP_PUT, 8'h71);
        send_request(OP_PUT, CH_BACKSPACE);
        settle();

        // text mode at full width: backspace wrap to column 4094, then the
        // column runs past 4095 and wraps to 0
        configure(4095, 4095, 1'b1, $urandom(), $urandom());
        send_request(OP_PUT, CH_NEWLINE);
        send_request(OP_PUT, CH_BACKSPACE);
        send_request(OP_PUT, 8'h6D);
        send_request(OP_PUT, 8'h6E);
        send_request(OP_PUT, CH_BACKSPACE);
        send_request(OP_PUT, CH_RETURN);
        settle();

        // random phases, each with fresh settings
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            configure(pick_extent(), pick_extent(), $urandom_range(1), $urandom(), $urandom());
            // one whole phase runs with both sides always ready
            calm = (p == 1);
            for (int k = 0; k < REQ_PER_PHASE; k++)
            begin
                // sender holds off mid-phase until every command is back
                if (p == 3 && k == REQ_PER_PHASE / 2)
                    settle();
                r   = $urandom_range(99);
                rop = OP_PUT;
                rch = 8'($urandom_range(255));
                if (r < 4)
                    rop = OP_CLEAR;
                else if (r < 14)
                    rch = CH_NEWLINE;
                else if (r < 24)
                    rch = CH_BACKSPACE;
                else if (r < 32)
                    rch = CH_TAB;
                else if (r < 37)
                    rch = CH_RETURN;
                send_request(rop, rch);
            end
            settle();
        end
        calm = 1'b0;

        if (tracker.pending() != 0)
            tracker.report_mismatch($sformatf("%0d commands never arrived", tracker.pending()));

        $display("covered %0d requests over %0d register settings",
                 tracker.n_req, settings_used);
        $display("checked %0d commands: %0d draws, %0d scrolls, %0d clears",
                 tracker.n_seen, tracker.n_draw, tracker.n_scroll, tracker.n_clear);
        if (tracker.errors == 0)
            $display("console_cursor_controller_top test passed");
        else
            $display("console_cursor_controller_top test failed");
        $finish;
    end

    // hard stop if the run hangs
    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("timeout with %0d commands outstanding", tracker.pending());
        $display("console_cursor_controller_top test failed");
        $finish;
    end

endmodule
